>>> sv/lavm_pkg.sv
// Shared constants for the look-at view matrix block.
package lavm_pkg;

  // Default number of fraction bits in the fixed-point words.
  localparam int FRAC_BITS_DEF = 16;

  // Normalizing puts the largest component magnitude at this bit position.
  localparam int NORM_TOP = 29;

  // Matrix row codes.
  localparam logic [1:0] ROW_X = 2'd0;
  localparam logic [1:0] ROW_Y = 2'd1;
  localparam logic [1:0] ROW_Z = 2'd2;
  localparam logic [1:0] ROW_W = 2'd3;

endpackage

>>> sv/lavm_norm.sv
// Pipelined vector normalizer: magnitude, scaling, square root and division stages.
module lavm_norm import lavm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int IN_W = 33,
  parameter int SIDE_W = 1
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [IN_W-1:0] vec [3],
  input  logic [SIDE_W-1:0] in_side,
  output logic out_valid,
  output logic signed [FRAC_BITS+1:0] unit [3],
  output logic zero_len,
  output logic [SIDE_W-1:0] out_side
);

  localparam int PW = $clog2(IN_W);
  localparam int CW = NORM_TOP + 1;
  localparam int SQ_STEPS = 32;
  localparam int QW = FRAC_BITS + 1;
  localparam int UW = FRAC_BITS + 2;
  localparam int DW = FRAC_BITS + 33;
  localparam int T_SQ0 = 5;
  localparam int T_DIV0 = T_SQ0 + SQ_STEPS + 1;
  localparam int T_OUT = T_DIV0 + QW + 1;

  // Control and sideband that travel with every stage.
  logic              mv  [1:T_OUT];
  logic [SIDE_W-1:0] ms  [1:T_OUT];
  logic [2:0]        msg [1:T_OUT-1];
  logic              mz  [2:T_OUT];

  logic [IN_W-1:0] mag_c [3];
  logic [IN_W-1:0] mag1 [3];
  logic [IN_W-1:0] or1;
  logic [IN_W-1:0] mag2 [3];
  logic [PW-1:0]   pos_c;
  logic [PW-1:0]   pos2;
  logic [CW-1:0]   sh_c [3];
  logic [CW-1:0]   mc [3:T_DIV0-1][3];
  logic [2*CW-1:0] sq4 [3];
  logic [63:0]     sqn [T_SQ0:T_SQ0+SQ_STEPS-1];
  logic [63:0]     sqr [T_SQ0:T_SQ0+SQ_STEPS];
  logic [31:0]     len;
  logic [DW-1:0]   dr [T_DIV0:T_DIV0+QW-1][3];
  logic [31:0]     dlen [T_DIV0:T_DIV0+QW-1];
  logic [QW-1:0]   dq [T_DIV0:T_DIV0+QW][3];
  logic signed [UW-1:0] unit_c [3];

  // Stage 1: component magnitudes and their OR for the leading-one search.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = vec[i][IN_W-1] ? -vec[i] : vec[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mv[1] <= 1'b0;
    end else if (en) begin
      mv[1] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ms[1] <= in_side;
      for (int i = 0; i < 3; i++) begin
        msg[1][i] <= vec[i][IN_W-1];
        mag1[i] <= mag_c[i];
      end
      or1 <= mag_c[0] | mag_c[1] | mag_c[2];
    end
  end

  // Stage 2: position of the leading one of the largest magnitude.
  always_comb begin
    pos_c = '0;
    for (int b = 0; b < IN_W; b++) begin
      if (or1[b]) begin
        pos_c = PW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag2 <= mag1;
      pos2 <= pos_c;
      mz[2] <= (or1 == '0);
    end
  end

  // Stage 3: scale so the largest magnitude sits just below 2^30.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pos2 > PW'(NORM_TOP)) begin
        sh_c[i] = CW'(mag2[i] >> (pos2 - PW'(NORM_TOP)));
      end else begin
        sh_c[i] = CW'(mag2[i] << (PW'(NORM_TOP) - pos2));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mc[3] <= sh_c;
    end
  end

  // Stage 4: squares. Stage 5: sum of squares, start of the root.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq4[i] <= mc[3][i] * mc[3][i];
      end
      sqn[T_SQ0] <= 64'(sq4[0]) + 64'(sq4[1]) + 64'(sq4[2]);
      sqr[T_SQ0] <= '0;
    end
  end

  // Scaled components ride along until the division needs them.
  for (genvar t = 4; t < T_DIV0; t++) begin : g_comp
    always_ff @(posedge clk) begin
      if (en) begin
        mc[t] <= mc[t-1];
      end
    end
  end

  // Integer square root, one result bit per stage.
  for (genvar t = T_SQ0 + 1; t <= T_SQ0 + SQ_STEPS; t++) begin : g_sqrt
    localparam logic [63:0] BITV = 64'(1) << (2 * (T_SQ0 + SQ_STEPS - t));
    logic [63:0] trial;
    logic        fits;
    assign trial = sqr[t-1] + BITV;
    assign fits = (sqn[t-1] >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        sqr[t] <= fits ? (sqr[t-1] >> 1) + BITV : sqr[t-1] >> 1;
      end
    end

    if (t < T_SQ0 + SQ_STEPS) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          sqn[t] <= fits ? sqn[t-1] - trial : sqn[t-1];
        end
      end
    end
  end

  assign len = sqr[T_SQ0+SQ_STEPS][31:0];

  // Division setup: scaled component plus half the length for rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      dlen[T_DIV0] <= len;
      for (int i = 0; i < 3; i++) begin
        dr[T_DIV0][i] <= (DW'(mc[T_DIV0-1][i]) << FRAC_BITS) + DW'(len >> 1);
        dq[T_DIV0][i] <= '0;
      end
    end
  end

  // Restoring division, one quotient bit per stage, three lanes.
  for (genvar t = T_DIV0 + 1; t <= T_DIV0 + QW; t++) begin : g_div
    localparam int K = T_DIV0 + QW - t;
    logic [DW-1:0] dsh;
    logic [2:0]    ge;
    assign dsh = DW'(dlen[t-1]) << K;

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = (dr[t-1][i] >= dsh);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          dq[t][i] <= ge[i] ? (dq[t-1][i] | (QW'(1) << K)) : dq[t-1][i];
        end
      end
    end

    if (t < T_DIV0 + QW) begin : g_pass
      always_ff @(posedge clk) begin
        if (en) begin
          dlen[t] <= dlen[t-1];
          for (int i = 0; i < 3; i++) begin
            dr[t][i] <= ge[i] ? dr[t-1][i] - dsh : dr[t-1][i];
          end
        end
      end
    end
  end

  // Meta pipeline.
  for (genvar t = 2; t <= T_OUT; t++) begin : g_meta
    always_ff @(posedge clk) begin
      if (rst) begin
        mv[t] <= 1'b0;
      end else if (en) begin
        mv[t] <= mv[t-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ms[t] <= ms[t-1];
      end
    end

    if (t < T_OUT) begin : g_sgn
      always_ff @(posedge clk) begin
        if (en) begin
          msg[t] <= msg[t-1];
        end
      end
    end

    if (t > 2) begin : g_zero
      always_ff @(posedge clk) begin
        if (en) begin
          mz[t] <= mz[t-1];
        end
      end
    end
  end

  // Output stage: restore signs, zero vectors give zero axes.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (mz[T_OUT-1]) begin
        unit_c[i] = '0;
      end else if (msg[T_OUT-1][i]) begin
        unit_c[i] = -signed'({1'b0, dq[T_OUT-1][i]});
      end else begin
        unit_c[i] = signed'({1'b0, dq[T_OUT-1][i]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit <= unit_c;
    end
  end

  assign out_valid = mv[T_OUT];
  assign zero_len = mz[T_OUT];
  assign out_side = ms[T_OUT];

endmodule

>>> sv/look_at_view_matrix.sv
// Words are Q16.16 at the default FRAC_BITS; each accepted word yields four output rows,
// and while those rows are being sent, no new word is taken.
// Every stage takes a new word each cycle; the row serializer at the end stalls
// the whole pipeline while it is busy. Each normalizer holds a 32-stage root
// and a FRAC_BITS+1 stage divider. Reset clears all valid bits and the row counter.
module look_at_view_matrix import lavm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] eye_x,
  input  logic signed [31:0] eye_y,
  input  logic signed [31:0] eye_z,
  input  logic signed [31:0] look_x,
  input  logic signed [31:0] look_y,
  input  logic signed [31:0] look_z,
  input  logic signed [31:0] up_x,
  input  logic signed [31:0] up_y,
  input  logic signed [31:0] up_z,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] row_index,
  output logic signed [31:0] elem_0,
  output logic signed [31:0] elem_1,
  output logic signed [31:0] elem_2,
  output logic signed [31:0] elem_3,
  output logic degenerate,
  output logic last_row
);

  localparam int UW = FRAC_BITS + 2;
  localparam int YW = FRAC_BITS + 3;
  localparam int ZW = 33;
  localparam int XW = FRAC_BITS + 35;
  localparam int P1W = 32 + UW;
  localparam int PQW = 2 * UW;
  localparam int PDW = PQW + 1;
  localparam int EYW = 32 + YW;
  localparam int DOTW = FRAC_BITS + 37;
  localparam int S1W = 192;
  localparam int S2W = 1 + 3 * UW + 96;
  localparam logic signed [UW-1:0] ONE_U = UW'(1) << FRAC_BITS;

  logic en;

  // Round to nearest, ties away from zero, after dropping FRAC_BITS.
  function automatic logic signed [YW-1:0] round_y(input logic signed [PDW-1:0] d);
    logic [PDW-1:0] m;
    logic [PDW-1:0] r;
    m = d[PDW-1] ? -d : d;
    r = (m + (PDW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return d[PDW-1] ? -signed'(YW'(r)) : signed'(YW'(r));
  endfunction

  // Rounded, negated and saturated translation term.
  function automatic logic [31:0] sat_neg(input logic signed [DOTW-1:0] d);
    logic [DOTW-1:0] m;
    logic [DOTW-1:0] r;
    logic [31:0]     t;
    m = d[DOTW-1] ? -d : d;
    r = (m + (DOTW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (d[DOTW-1]) begin
      t = (r > DOTW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : r[31:0];
    end else begin
      t = (r > DOTW'(32'h8000_0000)) ? 32'h8000_0000 : (~r[31:0]) + 32'd1;
    end
    return t;
  endfunction

  // View direction and first normalizer.
  logic signed [ZW-1:0] zr [3];
  logic [S1W-1:0]       side1;
  logic                 n1_v;
  logic signed [UW-1:0] n1_za [3];
  logic                 n1_zero;
  logic [S1W-1:0]       n1_side;
  logic signed [31:0]   n1_up [3];

  assign zr[0] = {look_x[31], look_x} - {eye_x[31], eye_x};
  assign zr[1] = {look_y[31], look_y} - {eye_y[31], eye_y};
  assign zr[2] = {look_z[31], look_z} - {eye_z[31], eye_z};
  assign side1 = {up_z, up_y, up_x, eye_z, eye_y, eye_x};

  lavm_norm #(
    .FRAC_BITS(FRAC_BITS),
    .IN_W(ZW),
    .SIDE_W(S1W)
  ) u_norm_z (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(in_valid),
    .vec(zr),
    .in_side(side1),
    .out_valid(n1_v),
    .unit(n1_za),
    .zero_len(n1_zero),
    .out_side(n1_side)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n1_up[j] = n1_side[96+32*j +: 32];
    end
  end

  // Cross product up x z: products, then differences.
  logic                 xa_v;
  logic signed [P1W-1:0] xp [6];
  logic signed [UW-1:0] xa_za [3];
  logic [95:0]          xa_eye;
  logic                 xa_deg;
  logic                 xb_v;
  logic signed [XW-1:0] xr [3];
  logic signed [UW-1:0] xb_za [3];
  logic [95:0]          xb_eye;
  logic                 xb_deg;

  always_ff @(posedge clk) begin
    if (rst) begin
      xa_v <= 1'b0;
      xb_v <= 1'b0;
    end else if (en) begin
      xa_v <= n1_v;
      xb_v <= xa_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp[0] <= n1_up[1] * n1_za[2];
      xp[1] <= n1_up[2] * n1_za[1];
      xp[2] <= n1_up[2] * n1_za[0];
      xp[3] <= n1_up[0] * n1_za[2];
      xp[4] <= n1_up[0] * n1_za[1];
      xp[5] <= n1_up[1] * n1_za[0];
      xa_za <= n1_za;
      xa_eye <= n1_side[95:0];
      xa_deg <= n1_zero;
      xr[0] <= XW'(xp[0]) - XW'(xp[1]);
      xr[1] <= XW'(xp[2]) - XW'(xp[3]);
      xr[2] <= XW'(xp[4]) - XW'(xp[5]);
      xb_za <= xa_za;
      xb_eye <= xa_eye;
      xb_deg <= xa_deg;
    end
  end

  // Second normalizer for the x axis.
  logic [S2W-1:0]       side2;
  logic                 n2_v;
  logic signed [UW-1:0] n2_xa [3];
  logic                 n2_zero;
  logic [S2W-1:0]       n2_side;
  logic signed [UW-1:0] n2_za [3];
  logic signed [31:0]   n2_eye [3];

  assign side2 = {xb_deg, xb_za[2], xb_za[1], xb_za[0], xb_eye};

  lavm_norm #(
    .FRAC_BITS(FRAC_BITS),
    .IN_W(XW),
    .SIDE_W(S2W)
  ) u_norm_x (
    .clk(clk),
    .rst(rst),
    .en(en),
    .in_valid(xb_v),
    .vec(xr),
    .in_side(side2),
    .out_valid(n2_v),
    .unit(n2_xa),
    .zero_len(n2_zero),
    .out_side(n2_side)
  );

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      n2_eye[j] = n2_side[32*j +: 32];
      n2_za[j] = n2_side[96+UW*j +: UW];
    end
  end

  // Y axis products and eye dot products for x and z.
  logic                  ya_v;
  logic signed [PQW-1:0] yq [6];
  logic signed [P1W-1:0] yex [3];
  logic signed [P1W-1:0] yez [3];
  logic signed [UW-1:0]  ya_xa [3];
  logic signed [UW-1:0]  ya_za [3];
  logic signed [31:0]    ya_eye [3];
  logic                  ya_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      yq[0] <= n2_za[1] * n2_xa[2];
      yq[1] <= n2_za[2] * n2_xa[1];
      yq[2] <= n2_za[2] * n2_xa[0];
      yq[3] <= n2_za[0] * n2_xa[2];
      yq[4] <= n2_za[0] * n2_xa[1];
      yq[5] <= n2_za[1] * n2_xa[0];
      for (int j = 0; j < 3; j++) begin
        yex[j] <= n2_xa[j] * n2_eye[j];
        yez[j] <= n2_za[j] * n2_eye[j];
      end
      ya_xa <= n2_xa;
      ya_za <= n2_za;
      ya_eye <= n2_eye;
      ya_deg <= n2_side[S2W-1] | n2_zero;
    end
  end

  // Y axis rounding, dot sums for x and z.
  logic                   yb_v;
  logic signed [YW-1:0]   yb_ya [3];
  logic signed [DOTW-1:0] yb_dx;
  logic signed [DOTW-1:0] yb_dz;
  logic signed [UW-1:0]   yb_xa [3];
  logic signed [UW-1:0]   yb_za [3];
  logic signed [31:0]     yb_eye [3];
  logic                   yb_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      yb_ya[0] <= round_y(PDW'(yq[0]) - PDW'(yq[1]));
      yb_ya[1] <= round_y(PDW'(yq[2]) - PDW'(yq[3]));
      yb_ya[2] <= round_y(PDW'(yq[4]) - PDW'(yq[5]));
      yb_dx <= DOTW'(yex[0]) + DOTW'(yex[1]) + DOTW'(yex[2]);
      yb_dz <= DOTW'(yez[0]) + DOTW'(yez[1]) + DOTW'(yez[2]);
      yb_xa <= ya_xa;
      yb_za <= ya_za;
      yb_eye <= ya_eye;
      yb_deg <= ya_deg;
    end
  end

  // Eye products for y, translations for x and z.
  logic                  yc_v;
  logic signed [EYW-1:0] yc_ey [3];
  logic [31:0]           yc_tx;
  logic [31:0]           yc_tz;
  logic signed [UW-1:0]  yc_xa [3];
  logic signed [YW-1:0]  yc_ya [3];
  logic signed [UW-1:0]  yc_za [3];
  logic                  yc_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        yc_ey[j] <= yb_ya[j] * yb_eye[j];
      end
      yc_tx <= sat_neg(yb_dx);
      yc_tz <= sat_neg(yb_dz);
      yc_xa <= yb_xa;
      yc_ya <= yb_ya;
      yc_za <= yb_za;
      yc_deg <= yb_deg;
    end
  end

  // Dot sum for y, then its translation.
  logic                   yd_v;
  logic signed [DOTW-1:0] yd_dy;
  logic [31:0]            yd_tx;
  logic [31:0]            yd_tz;
  logic signed [UW-1:0]   yd_xa [3];
  logic signed [YW-1:0]   yd_ya [3];
  logic signed [UW-1:0]   yd_za [3];
  logic                   yd_deg;
  logic                   ye_v;
  logic [31:0]            ye_tx;
  logic [31:0]            ye_ty;
  logic [31:0]            ye_tz;
  logic signed [UW-1:0]   ye_xa [3];
  logic signed [YW-1:0]   ye_ya [3];
  logic signed [UW-1:0]   ye_za [3];
  logic                   ye_deg;

  always_ff @(posedge clk) begin
    if (en) begin
      yd_dy <= DOTW'(yc_ey[0]) + DOTW'(yc_ey[1]) + DOTW'(yc_ey[2]);
      yd_tx <= yc_tx;
      yd_tz <= yc_tz;
      yd_xa <= yc_xa;
      yd_ya <= yc_ya;
      yd_za <= yc_za;
      yd_deg <= yc_deg;
      ye_ty <= sat_neg(yd_dy);
      ye_tx <= yd_tx;
      ye_tz <= yd_tz;
      ye_xa <= yd_xa;
      ye_ya <= yd_ya;
      ye_za <= yd_za;
      ye_deg <= yd_deg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ya_v <= 1'b0;
      yb_v <= 1'b0;
      yc_v <= 1'b0;
      yd_v <= 1'b0;
      ye_v <= 1'b0;
    end else if (en) begin
      ya_v <= n2_v;
      yb_v <= ya_v;
      yc_v <= yb_v;
      yd_v <= yc_v;
      ye_v <= yd_v;
    end
  end

  // Row serializer: holds one finished matrix and sends its four rows.
  logic                 ser_v;
  logic [1:0]           row_cnt;
  logic signed [UW-1:0] ser_xa [3];
  logic signed [YW-1:0] ser_ya [3];
  logic signed [UW-1:0] ser_za [3];
  logic [31:0]          ser_tx;
  logic [31:0]          ser_ty;
  logic [31:0]          ser_tz;
  logic                 ser_deg;

  assign en = !ser_v || (out_ready && row_cnt == ROW_W);
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_v <= 1'b0;
      row_cnt <= ROW_X;
    end else if (en) begin
      ser_v <= ye_v;
      row_cnt <= ROW_X;
    end else if (out_ready) begin
      row_cnt <= row_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ser_xa <= ye_xa;
      ser_ya <= ye_ya;
      ser_za <= ye_za;
      ser_tx <= ye_tx;
      ser_ty <= ye_ty;
      ser_tz <= ye_tz;
      ser_deg <= ye_deg;
    end
  end

  // Row select for the output word.
  always_comb begin
    case (row_cnt)
      ROW_X: begin
        elem_0 = {{(32-UW){ser_xa[0][UW-1]}}, ser_xa[0]};
        elem_1 = {{(32-UW){ser_xa[1][UW-1]}}, ser_xa[1]};
        elem_2 = {{(32-UW){ser_xa[2][UW-1]}}, ser_xa[2]};
        elem_3 = ser_tx;
      end
      ROW_Y: begin
        elem_0 = {{(32-YW){ser_ya[0][YW-1]}}, ser_ya[0]};
        elem_1 = {{(32-YW){ser_ya[1][YW-1]}}, ser_ya[1]};
        elem_2 = {{(32-YW){ser_ya[2][YW-1]}}, ser_ya[2]};
        elem_3 = ser_ty;
      end
      ROW_Z: begin
        elem_0 = {{(32-UW){ser_za[0][UW-1]}}, ser_za[0]};
        elem_1 = {{(32-UW){ser_za[1][UW-1]}}, ser_za[1]};
        elem_2 = {{(32-UW){ser_za[2][UW-1]}}, ser_za[2]};
        elem_3 = ser_tz;
      end
      default: begin
        elem_0 = '0;
        elem_1 = '0;
        elem_2 = '0;
        elem_3 = 32'(1) << FRAC_BITS;
      end
    endcase
  end

  assign out_valid = ser_v;
  assign row_index = row_cnt;
  assign degenerate = ser_deg;
  assign last_row = (row_cnt == ROW_W);

  // A taken row that is not the last moves to the next row of the same matrix.
  a_row_step: assert property (@(posedge clk) disable iff (rst)
    ser_v && out_ready && row_cnt != ROW_W |=> ser_v && row_cnt == $past(row_cnt) + 2'd1)
    else $error("row counter did not advance within a matrix");

  // A new matrix always starts at row zero.
  a_row_start: assert property (@(posedge clk) disable iff (rst)
    en && ye_v |=> ser_v && row_cnt == ROW_X)
    else $error("new matrix did not start at row zero");

  // The degenerate flag holds for all rows of one matrix.
  a_deg_hold: assert property (@(posedge clk) disable iff (rst)
    ser_v && !en |=> $stable(ser_deg))
    else $error("degenerate flag changed within a matrix");

  // The first normalized x axis component never exceeds one in magnitude unless degenerate.
  a_unit_bound: assert property (@(posedge clk) disable iff (rst)
    ser_v && !ser_deg |-> ser_xa[0] <= ONE_U && ser_xa[0] >= -ONE_U)
    else $error("x axis component out of unit range");

endmodule
